FILE: src/srd_pkg.sv
`default_nettype none
package srd_pkg;

    localparam int HDR_CNT_W = 10;
    localparam int POS_W     = 24;

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_YSTEP = 2'd1;
    localparam logic [1:0] PH_XSTEP = 2'd2;

    localparam logic [7:0] FLAG_NEG_X     = 8'h20;
    localparam logic [7:0] FLAG_NEG_Y     = 8'h40;
    localparam logic [7:0] FLAG_CHG_MASK  = 8'h98;
    localparam logic [7:0] FLAG_CHG_CODE  = 8'h88;
    localparam logic [7:0] FLAG_HIDDEN    = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    point_visible;
        logic                    color_change;
        logic [7:0]              color_slot;
        logic                    default_color;
        logic                    end_of_stream;
    } t_out_item;

endpackage
`default_nettype wire

FILE: src/stitch_record_decoder.sv
`default_nettype none
// A result goes into the single result register as the x step byte of its record is taken;
// it refills while read out. Throughput: one byte per cycle unless output stalls.
// Reset: synchronous, active low; clears parser state, positions, colour and palette count.
// A byte flagged last returns the parser to its reset state (palette count holds).
module stitch_record_decoder
    import srd_pkg::*;
#(
    parameter int HEADER_BYTES = 512,
    parameter int COORD_WIDTH  = 24
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic [HDR_CNT_W-1:0]          r_hdr_cnt,  n_hdr_cnt;
    logic [1:0]                    r_phase,    n_phase;
    logic [7:0]                    r_flag,     n_flag;
    logic [7:0]                    r_ystep,    n_ystep;
    logic signed [COORD_WIDTH-1:0] r_run_x,    n_run_x;
    logic signed [COORD_WIDTH-1:0] r_run_y,    n_run_y;
    logic [7:0]                    r_color,    n_color;
    logic                          r_over,     n_over;
    logic [7:0]                    r_palette;
    logic                          r_out_valid;
    t_out_item                     r_out,      n_out;

    logic                          accept;
    logic                          produce;
    logic                          change;
    logic [8:0]                    next_slot;
    logic signed [COORD_WIDTH-1:0] step_x, step_y;
    logic signed [31:0]            ext_x, ext_y;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    srd_axis_step #(.COORD_WIDTH(COORD_WIDTH)) u_step_x (
        .i_run    (r_run_x),
        .i_step   (i_in_item.data_byte),
        .i_negate ((r_flag & FLAG_NEG_X) != 8'h00),
        .o_run    (step_x)
    );

    srd_axis_step #(.COORD_WIDTH(COORD_WIDTH)) u_step_y (
        .i_run    (r_run_y),
        .i_step   (r_ystep),
        .i_negate ((r_flag & FLAG_NEG_Y) != 8'h00),
        .o_run    (step_y)
    );

    assign change    = (r_flag & FLAG_CHG_MASK) == FLAG_CHG_CODE;
    assign next_slot = {1'b0, r_color} + 9'd1;

    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_phase   = r_phase;
        n_flag    = r_flag;
        n_ystep   = r_ystep;
        n_run_x   = r_run_x;
        n_run_y   = r_run_y;
        n_color   = r_color;
        n_over    = r_over;
        produce   = 1'b0;

        if (r_hdr_cnt < HDR_CNT_W'(HEADER_BYTES)) begin
            n_hdr_cnt = r_hdr_cnt + 1'b1;
        end else begin
            case (r_phase)
                PH_YSTEP: begin
                    n_ystep = i_in_item.data_byte;
                    n_phase = PH_XSTEP;
                end
                PH_XSTEP: begin
                    n_run_x = step_x;
                    n_run_y = step_y;
                    if (change) begin
                        if (next_slot < {1'b0, r_palette}) begin
                            n_color = next_slot[7:0];
                        end else begin
                            n_over = 1'b1;
                        end
                    end
                    produce = 1'b1;
                    n_phase = PH_FLAG;
                end
                default: begin
                    n_flag  = i_in_item.data_byte;
                    n_phase = PH_YSTEP;
                end
            endcase
        end

        ext_x = 32'(n_run_x);
        ext_y = 32'(n_run_y);

        n_out.pos_x         = ext_x[POS_W-1:0];
        n_out.pos_y         = ext_y[POS_W-1:0];
        n_out.point_visible = (r_flag & FLAG_HIDDEN) == 8'h00;
        n_out.color_change  = change;
        n_out.color_slot    = n_color;
        n_out.default_color = n_over || (r_palette == 8'd0);
        n_out.end_of_stream = i_in_item.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt   <= '0;
            r_phase     <= PH_FLAG;
            r_flag      <= '0;
            r_ystep     <= '0;
            r_run_x     <= '0;
            r_run_y     <= '0;
            r_color     <= '0;
            r_over      <= 1'b0;
            r_palette   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_palette <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= produce;
                if (i_in_item.last_byte) begin
                    // drop whatever record or header was in progress
                    r_hdr_cnt <= '0;
                    r_phase   <= PH_FLAG;
                    r_flag    <= '0;
                    r_ystep   <= '0;
                    r_run_x   <= '0;
                    r_run_y   <= '0;
                    r_color   <= '0;
                    r_over    <= 1'b0;
                end else begin
                    r_hdr_cnt <= n_hdr_cnt;
                    r_phase   <= n_phase;
                    r_flag    <= n_flag;
                    r_ystep   <= n_ystep;
                    r_run_x   <= n_run_x;
                    r_run_y   <= n_run_y;
                    r_color   <= n_color;
                    r_over    <= n_over;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

FILE: src/srd_axis_step.sv
`default_nettype none
module srd_axis_step #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic signed [COORD_WIDTH-1:0] i_run,
    input  wire logic        [7:0]             i_step,
    input  wire logic                          i_negate,
    output logic signed      [COORD_WIDTH-1:0] o_run
);

    logic signed [COORD_WIDTH:0] step_ext;
    logic signed [COORD_WIDTH:0] sum;

    always_comb begin
        step_ext = (COORD_WIDTH+1)'(signed'(i_step));
        if (i_negate) begin
            step_ext = -step_ext;
        end
        sum = {i_run[COORD_WIDTH-1], i_run} + step_ext;
        // clamp when the top two bits disagree
        if (sum[COORD_WIDTH] != sum[COORD_WIDTH-1]) begin
            o_run = sum[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                     : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else begin
            o_run = sum[COORD_WIDTH-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: bench/srd_bench_pkg.sv
package srd_bench_pkg;
    import srd_pkg::*;

    localparam int HDR_LEN = 512;

    // Tracks the decoder state byte by byte and holds the records it must emit.
    class stitch_record_book;
        logic [7:0]  palette;
        int unsigned hdr_seen;
        logic [1:0]  phase;
        logic [7:0]  flag_byte;
        logic [7:0]  ystep_byte;
        int          run_x;
        int          run_y;
        logic [7:0]  slot;
        bit          past_palette;
        t_out_item   records[$];
        int          mismatches;
        int          seen;

        function new();
            palette    = '0;
            mismatches = 0;
            seen       = 0;
            restart();
        endfunction

        function void restart();
            hdr_seen     = 0;
            phase        = PH_FLAG;
            flag_byte    = '0;
            ystep_byte   = '0;
            run_x        = 0;
            run_y        = 0;
            slot         = '0;
            past_palette = 1'b0;
        endfunction

        function void set_palette(logic [7:0] v);
            palette = v;
        endfunction

        function int pending();
            return records.size();
        endfunction

        static function int step_of(logic [7:0] b, bit flip);
            int v;
            v = int'($signed(b));
            return flip ? -v : v;
        endfunction

        static function int clamp(int v);
            int hi;
            int lo;
            hi = (1 << (POS_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function void take_byte(t_in_item it);
            t_out_item r;
            bit        chg;
            int        nxt;
            if (hdr_seen < HDR_LEN) begin
                hdr_seen++;
            end else if (phase == PH_YSTEP) begin
                ystep_byte = it.data_byte;
                phase      = PH_XSTEP;
            end else if (phase == PH_XSTEP) begin
                chg   = (flag_byte & FLAG_CHG_MASK) == FLAG_CHG_CODE;
                run_x = clamp(run_x + step_of(it.data_byte, (flag_byte & FLAG_NEG_X) != 0));
                run_y = clamp(run_y + step_of(ystep_byte, (flag_byte & FLAG_NEG_Y) != 0));
                if (chg) begin
                    nxt = int'(slot) + 1;
                    // hold the slot once the palette runs out
                    if (nxt < int'(palette)) slot = nxt[7:0];
                    else past_palette = 1'b1;
                end
                r.pos_x         = run_x[POS_W-1:0];
                r.pos_y         = run_y[POS_W-1:0];
                r.point_visible = (flag_byte & FLAG_HIDDEN) == 0;
                r.color_change  = chg;
                r.color_slot    = slot;
                r.default_color = past_palette || palette == 0;
                r.end_of_stream = it.last_byte;
                records.push_back(r);
                phase = PH_FLAG;
            end else begin
                flag_byte = it.data_byte;
                phase     = PH_YSTEP;
            end
            if (it.last_byte) restart();
        endfunction

        function bit field_ok(string name, logic signed [63:0] want, logic signed [63:0] got);
            if (want === got) return 1'b1;
            if (mismatches < 10)
                $display("record %0d %s: expected %0d, got %0d", seen, name, want, got);
            return 1'b0;
        endfunction

        function void match_record(t_out_item got);
            t_out_item want;
            bit        bad;
            if (records.size() == 0) begin
                if (mismatches < 10)
                    $display("record %0d arrived with nothing expected", seen);
                mismatches++;
                seen++;
                return;
            end
            want = records.pop_front();
            bad  = 1'b0;
            bad |= !field_ok("pos_x", want.pos_x, got.pos_x);
            bad |= !field_ok("pos_y", want.pos_y, got.pos_y);
            bad |= !field_ok("point_visible", want.point_visible, got.point_visible);
            bad |= !field_ok("color_change", want.color_change, got.color_change);
            bad |= !field_ok("color_slot", want.color_slot, got.color_slot);
            bad |= !field_ok("default_color", want.default_color, got.default_color);
            bad |= !field_ok("end_of_stream", want.end_of_stream, got.end_of_stream);
            if (bad) mismatches++;
            seen++;
        endfunction
    endclass

endpackage

FILE: bench/stitch_record_decoder_test.sv
module stitch_record_decoder_test;
    import srd_pkg::*;
    import srd_bench_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int SAT_RECORDS   = 65540;
    localparam int RANDOM_BYTES  = 550;
    localparam int LIMIT         = 2_000_000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_item;
    logic       cfg_ready;

    bit calm = 1'b0;
    int cycle_count = 0;

    stitch_record_book book = new();

    stitch_record_decoder #(
        .HEADER_BYTES(HDR_LEN),
        .COORD_WIDTH (POS_W)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Results are checked before the byte of the same edge is noted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) book.match_record(out_item);
            if (in_valid && in_ready) book.take_byte(in_item);
            if (cfg_valid && cfg_ready) book.set_palette(cfg_data);
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] pick_palette();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd2;
            3: return 8'd255;
            default: return 8'($urandom_range(3, 40));
        endcase
    endfunction

    // Leave valid high on return so that a back-to-back item goes out with no gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.data_byte <= b;
        in_item.last_byte <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_record(input logic [7:0] fl, input logic [7:0] ys, input logic [7:0] xs,
                               input logic last);
        send_byte(fl, 1'b0);
        send_byte(ys, 1'b0);
        send_byte(xs, last);
    endtask

    task automatic send_header(input int count, input logic cut);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)), cut && i == count - 1);
    endtask

    // Drop valid and hold off until every record has come out.
    task automatic settle();
        in_valid <= 1'b0;
        // let the last accepted byte be noted before the count is read
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_palette(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        int         rec_bytes;
        int         n_rec;
        int         ending;
        bit         last_rec;
        logic [7:0] fl;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty palette from reset
        send_header(HDR_LEN, 1'b0);
        send_record(8'h00, 8'h7F, 8'h7F, 1'b0);
        send_record(8'h01, 8'h80, 8'h80, 1'b0);
        send_record(8'h20, 8'h05, 8'h80, 1'b0);
        send_record(8'h40, 8'h80, 8'hFF, 1'b0);
        send_record(8'h60, 8'hFF, 8'h01, 1'b0);
        send_record(8'h88, 8'h00, 8'h00, 1'b0);
        send_record(8'hFF, 8'h12, 8'h34, 1'b1);
        settle();

        write_palette(8'd255);
        send_header(100, 1'b1);
        send_header(HDR_LEN, 1'b0);
        send_record(8'h88, 8'h10, 8'hF0, 1'b0);
        send_record(8'hEF, 8'h10, 8'hF0, 1'b0);
        send_record(8'h98, 8'h01, 8'h01, 1'b0);
        send_record(8'h08, 8'h02, 8'h02, 1'b0);
        settle();
        // shrink the palette under the current slot
        write_palette(8'd2);
        send_record(8'h88, 8'h03, 8'h03, 1'b0);
        send_record(8'h00, 8'h04, 8'h04, 1'b0);
        settle();
        write_palette(8'd0);
        send_record(8'h80, 8'h05, 8'h05, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h11, 1'b1);
        settle();

        // drive both positions into saturation with no idling
        write_palette(8'd3);
        calm = 1'b1;
        send_header(HDR_LEN, 1'b0);
        repeat (SAT_RECORDS) send_record(8'h20, 8'h80, 8'h80, 1'b0);
        send_record(8'h68, 8'h80, 8'h80, 1'b0);
        send_record(8'h00, 8'h7F, 8'h80, 1'b1);
        calm = 1'b0;
        settle();

        rec_bytes = 0;
        while (rec_bytes < RANDOM_BYTES) begin
            write_palette(pick_palette());
            calm = $urandom_range(0, 4) == 0;
            if ($urandom_range(0, 9) == 0) send_header($urandom_range(1, HDR_LEN), 1'b1);
            send_header(HDR_LEN, 1'b0);
            n_rec = $urandom_range(2, 30);
            for (int r = 0; r < n_rec; r++) begin
                if ($urandom_range(0, 11) == 0) begin
                    settle();
                    write_palette(pick_palette());
                end
                fl = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0) fl = (fl & ~FLAG_CHG_MASK) | FLAG_CHG_CODE;
                last_rec = r == n_rec - 1;
                ending   = $urandom_range(0, 3);
                if (last_rec && ending == 0) begin
                    send_byte(fl, 1'b1);
                    rec_bytes += 1;
                end else if (last_rec && ending == 1) begin
                    send_byte(fl, 1'b0);
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    rec_bytes += 2;
                end else begin
                    send_record(fl, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                last_rec);
                    rec_bytes += 3;
                end
            end
            settle();
        end
        calm = 1'b0;

        settle();
        repeat (8) @(posedge clk);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
